// File: hdl/b58_pkg.sv
// Shared types, constants and the alphabet function of the base-58 encoder.
// No dependencies; the front end, queue and back end all use this package.
`default_nettype none

package b58_pkg;

	localparam int NUM_BYTES = 25;
	localparam int NUM_CHARS = 34;

	localparam int BIDX_W = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
	localparam int CIDX_W = (NUM_CHARS > 1) ? $clog2(NUM_CHARS) : 1;

	// Long division step: accumulator is remainder (below 58) times 256 plus a byte.
	localparam int ACC_W       = 14;
	localparam int RECIP_W     = 11;
	localparam int PROD_W      = ACC_W + RECIP_W;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP_58 = 11'd1129;
	localparam logic [ACC_W-1:0]   RADIX    = 14'd58;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} q_entry_t;

	function automatic logic [6:0] b58_char(input logic [5:0] dig);
		logic [7:0] c;
		c = 8'h31;
		case (dig) inside
			[6'd0:6'd8]:   c = 8'h31 + {2'b00, dig};
			[6'd9:6'd16]:  c = 8'h41 + {2'b00, dig} - 8'd9;
			[6'd17:6'd21]: c = 8'h4A + {2'b00, dig} - 8'd17;
			[6'd22:6'd32]: c = 8'h50 + {2'b00, dig} - 8'd22;
			[6'd33:6'd43]: c = 8'h61 + {2'b00, dig} - 8'd33;
			[6'd44:6'd57]: c = 8'h6D + {2'b00, dig} - 8'd44;
			default:       c = 8'h31;
		endcase
		return c[6:0];
	endfunction

endpackage

`default_nettype wire

// File: hdl/b58_front.sv
// Front end: accepts input bytes and tags the last byte of each number.
// Depends on b58_pkg for the byte count and the queue entry type.
`default_nettype none

module b58_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        in_byte,
	output logic                   push_valid,
	input  wire logic              push_ready,
	output b58_pkg::q_entry_t      push_entry
);

	localparam logic [b58_pkg::BIDX_W-1:0] LAST_BYTE = b58_pkg::BIDX_W'(b58_pkg::NUM_BYTES - 1);

	logic [b58_pkg::BIDX_W-1:0] count_q;

	assign in_ready        = push_ready;
	assign push_valid      = in_valid;
	assign push_entry.data = in_byte;
	assign push_entry.last = (count_q == LAST_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_valid && push_ready) begin
			if (count_q == LAST_BYTE) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/b58_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on b58_pkg for the entry type and depth constants.
`default_nettype none

module b58_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire b58_pkg::q_entry_t push_entry,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output b58_pkg::q_entry_t      pop_entry
);

	b58_pkg::q_entry_t           slot_q [b58_pkg::QDEPTH];
	logic [b58_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [b58_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [b58_pkg::QCNT_W-1:0]  count_q;
	logic                        push;
	logic                        pop;

	assign push_ready = (count_q != b58_pkg::QCNT_W'(b58_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/b58_back.sv
// Back end: loads the number, runs long division by 58 one byte per cycle,
// then reads the digit memory most significant first. Depends on b58_pkg.
`default_nettype none

module b58_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pop_valid,
	output logic                   pop_ready,
	input  wire b58_pkg::q_entry_t pop_entry,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [6:0]             out_char,
	output logic                   out_last
);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	localparam logic [b58_pkg::BIDX_W-1:0] LAST_BYTE = b58_pkg::BIDX_W'(b58_pkg::NUM_BYTES - 1);
	localparam logic [b58_pkg::CIDX_W-1:0] LAST_CHAR = b58_pkg::CIDX_W'(b58_pkg::NUM_CHARS - 1);

	state_t                      state_q;
	logic [b58_pkg::BIDX_W-1:0]  byte_idx_q;
	logic [b58_pkg::CIDX_W-1:0]  char_idx_q;
	logic [5:0]                  rem_q;
	logic                        out_valid_q;

	logic [7:0]                  num_q [b58_pkg::NUM_BYTES];
	logic [5:0]                  digit_mem [b58_pkg::NUM_CHARS];
	logic [5:0]                  rd_digit_q;
	logic                        out_last_q;

	logic [b58_pkg::ACC_W-1:0]   acc;
	logic [b58_pkg::PROD_W-1:0]  prod;
	logic [7:0]                  q_est;
	logic [b58_pkg::ACC_W-1:0]   q58_est;
	logic [b58_pkg::ACC_W-1:0]   r_est;
	logic [7:0]                  q_fix;
	logic [5:0]                  r_fix;
	logic                        load;
	logic                        rd_en;
	logic [b58_pkg::CIDX_W-1:0]  rd_addr;

	// One division step: reciprocal estimate, which is exact or one short.
	assign acc     = {rem_q, num_q[byte_idx_q]};
	assign prod    = b58_pkg::PROD_W'(acc) * b58_pkg::PROD_W'(b58_pkg::RECIP_58);
	assign q_est   = prod[b58_pkg::RECIP_SHIFT +: 8];
	assign q58_est = b58_pkg::ACC_W'({q_est, 5'b0}) + b58_pkg::ACC_W'({q_est, 4'b0})
	               + b58_pkg::ACC_W'({q_est, 3'b0}) + b58_pkg::ACC_W'({q_est, 1'b0});
	assign r_est   = acc - q58_est;

	always_comb begin
		if (r_est >= b58_pkg::RADIX) begin
			q_fix = q_est + 8'd1;
			r_fix = 6'(r_est - b58_pkg::RADIX);
		end else begin
			q_fix = q_est;
			r_fix = r_est[5:0];
		end
	end

	assign pop_ready = (state_q == ST_LOAD);
	assign load      = pop_valid && pop_ready;
	assign rd_en     = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign rd_addr   = LAST_CHAR - char_idx_q;

	assign out_valid = out_valid_q;
	assign out_char  = b58_pkg::b58_char(rd_digit_q);
	assign out_last  = out_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			num_q[byte_idx_q] <= pop_entry.data;
		end else if (state_q == ST_DIV) begin
			num_q[byte_idx_q] <= q_fix;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && (byte_idx_q == LAST_BYTE)) begin
			digit_mem[char_idx_q] <= r_fix;
		end
		if (rd_en) begin
			rd_digit_q <= digit_mem[rd_addr];
			out_last_q <= (char_idx_q == LAST_CHAR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			byte_idx_q  <= '0;
			char_idx_q  <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (load) begin
						if (pop_entry.last) begin
							state_q    <= ST_DIV;
							byte_idx_q <= '0;
							char_idx_q <= '0;
							rem_q      <= '0;
						end else begin
							byte_idx_q <= byte_idx_q + 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (byte_idx_q == LAST_BYTE) begin
						byte_idx_q <= '0;
						rem_q      <= '0;
						if (char_idx_q == LAST_CHAR) begin
							state_q    <= ST_EMIT;
							char_idx_q <= '0;
						end else begin
							char_idx_q <= char_idx_q + 1'b1;
						end
					end else begin
						byte_idx_q <= byte_idx_q + 1'b1;
						rem_q      <= r_fix;
					end
				end
				ST_EMIT: begin
					if (rd_en) begin
						out_valid_q <= 1'b1;
						if (char_idx_q == LAST_CHAR) begin
							state_q    <= ST_LOAD;
							byte_idx_q <= '0;
						end else begin
							char_idx_q <= char_idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < 6'd58))
		else $error("division remainder out of range");

	a_div_step_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |->
		((b58_pkg::ACC_W'(q_fix) * b58_pkg::RADIX + b58_pkg::ACC_W'(r_fix)) == acc)
		&& (r_fix < 6'd58))
		else $error("quotient estimate correction failed");

	a_last_char_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && (char_idx_q == LAST_CHAR)) |=>
		((state_q == ST_LOAD) && out_valid_q && out_last_q))
		else $error("final character not marked or emit not finished");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) || (state_q == ST_EMIT)) |=> $stable(byte_idx_q)
		|| (state_q == ST_DIV) || ($past(state_q) == ST_DIV) || (byte_idx_q == '0))
		else $error("byte index moved outside loading and division");
`endif

endmodule

`default_nettype wire

// File: hdl/base58_fixed_width_encoder.sv
// Fixed-width base-58 encoder: one number of NUM_BYTES bytes in, NUM_CHARS characters out.
// The wait from acceptance of the last byte to the first character being offered is set by the
// single divide-by-58 step that handles one byte per cycle.
// A new number is loaded only after all characters of the last one have been offered; characters
// then leave at one per cycle while out_ready is high.
// Reset clears all control state; the byte and digit stores stay undefined, no clearing pass.
`default_nettype none

module base58_fixed_width_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      out_char,
	output logic            out_last
);

	// The front end counts the incoming items and tags the final byte of each number,
	// so the back end starts dividing on that tag rather than on its own byte count.
	logic              push_valid;
	logic              push_ready;
	b58_pkg::q_entry_t push_entry;

	// The two-entry queue lets the first bytes of the next number wait while the back end
	// is still busy with the division or waiting on a stalled output.
	logic              pop_valid;
	logic              pop_ready;
	b58_pkg::q_entry_t pop_entry;

	b58_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	b58_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// The back end stores the number, divides it by 58 once per digit, least significant
	// digit first, and then reads the digits back most significant first. Zero high digits
	// simply come out as the padding character; overflowing high digits are dropped.
	b58_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.out_last  (out_last)
	);

endmodule

`default_nettype wire
